FILE: rtl/core/sorted_timer_queue_macros.svh
// Assertion macros used by the checker file of the timer queue.
// No dependencies; include by bare file name.
`ifndef SORTED_TIMER_QUEUE_MACROS_SVH
`define SORTED_TIMER_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define STQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("timer queue check failed");

// Next-cycle implication, disabled while reset is high.
`define STQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("timer queue check failed");

`endif

FILE: rtl/core/stq_pkg.sv
// Package for the sorted timer queue: sizes, codes and shared types.
// No dependencies.
package stq_pkg;

   localparam int DEPTH       = 16;
   localparam int TIME_BITS   = 32;
   localparam int HANDLE_BITS = 16;
   localparam int REARM_BITS  = 32;
   localparam int KIND_BITS   = 2;
   localparam int STATUS_BITS = 2;
   localparam int IDX_BITS    = $clog2(DEPTH);
   localparam int COUNT_BITS  = $clog2(DEPTH + 1);

   localparam logic [TIME_BITS-1:0] TIME_ALL_ONES = '1;

   localparam logic [KIND_BITS-1:0] KIND_ADD    = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_REMOVE = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_TICK   = 2'd2;
   localparam logic [KIND_BITS-1:0] KIND_EXEC   = 2'd3;

   localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY     = 2'd3;

   typedef enum logic [1:0] {
      SLOT_NONE,
      SLOT_INSERT,
      SLOT_DROP
   } slot_op_type;

   typedef struct packed {
      logic [TIME_BITS-1:0]   expiry;
      logic [HANDLE_BITS-1:0] handle;
      logic [TIME_BITS-1:0]   timeout;
   } slot_entry_type;

   typedef struct packed {
      slot_op_type          op;
      logic [IDX_BITS-1:0]  pos;
      slot_entry_type       entry;
   } slot_cmd_type;

   typedef struct packed {
      logic [TIME_BITS-1:0] sum;
      logic [TIME_BITS-1:0] diff;
      logic                 borrow;
      logic                 gt;
   } alu_res_type;

endpackage

FILE: rtl/core/stq_alu.sv
// Shared time arithmetic unit: add, subtract with borrow, unsigned compare.
// Depends on stq_pkg.
module stq_alu
   import stq_pkg::*;
(
   input  logic [TIME_BITS-1:0] op_a,
   input  logic [TIME_BITS-1:0] op_b,
   output alu_res_type          res
);

   logic [TIME_BITS:0] sub_wide;

   assign sub_wide   = {1'b0, op_a} - {1'b0, op_b};
   assign res.sum    = op_a + op_b;
   assign res.diff   = sub_wide[TIME_BITS-1:0];
   assign res.borrow = sub_wide[TIME_BITS];
   assign res.gt     = (op_a > op_b);

endmodule

FILE: rtl/core/stq_slots.sv
// Sorted slot store: one entry per timer, shifted up on insert, down on drop.
// Depends on stq_pkg.
module stq_slots
   import stq_pkg::*;
(
   input  logic                clock,
   input  slot_cmd_type        cmd,
   input  logic [IDX_BITS-1:0] rd_idx,
   output slot_entry_type      rd_data
);

   slot_entry_type slot_ff [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_slot
      slot_entry_type up_src;
      slot_entry_type down_src;

      if (i == 0) begin : g_first
         assign up_src = cmd.entry;
      end else begin : g_rest
         assign up_src = slot_ff[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign down_src = slot_ff[i];
      end else begin : g_inner
         assign down_src = slot_ff[i+1];
      end

      always_ff @(posedge clock) begin
         unique case (cmd.op)
            SLOT_INSERT: begin
               if (IDX_BITS'(i) == cmd.pos) begin
                  slot_ff[i] <= cmd.entry;
               end else if (IDX_BITS'(i) > cmd.pos) begin
                  slot_ff[i] <= up_src;
               end
            end
            SLOT_DROP: begin
               if (IDX_BITS'(i) >= cmd.pos) begin
                  slot_ff[i] <= down_src;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign rd_data = slot_ff[rd_idx];

endmodule

FILE: rtl/core/stq_ctrl.sv
// Sequencer of the timer queue: decodes commands, scans the slots one per
// cycle through the shared unit and forms the response. Depends on stq_pkg.
module stq_ctrl
   import stq_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [KIND_BITS-1:0]          req_kind,
   input  logic [TIME_BITS-1:0]          req_delay_ticks,
   input  logic [HANDLE_BITS-1:0]        req_target_handle,
   input  logic signed [REARM_BITS-1:0]  req_rearm_value,
   output logic                          rsp_valid,
   output logic [STATUS_BITS-1:0]        rsp_status,
   output logic [HANDLE_BITS-1:0]        rsp_result_handle,
   output logic [TIME_BITS-1:0]          rsp_time_to_head,
   output logic                          rsp_head_due,
   output logic [COUNT_BITS-1:0]         rsp_entry_count,
   output slot_cmd_type                  slot_cmd,
   output logic [IDX_BITS-1:0]           slot_rd_idx,
   input  slot_entry_type                slot_rd,
   output logic [TIME_BITS-1:0]          alu_a,
   output logic [TIME_BITS-1:0]          alu_b,
   input  alu_res_type                   alu_res
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK,
      ST_EXEC,
      ST_ADD_SUM,
      ST_SCAN,
      ST_SRCH,
      ST_RESULT
   } state_type;

   state_type               state_ff,  state_in;
   logic [TIME_BITS-1:0]    time_ff,   time_in;
   logic [HANDLE_BITS-1:0]  nhc_ff,    nhc_in;
   logic [COUNT_BITS-1:0]   count_ff,  count_in;
   logic [COUNT_BITS-1:0]   pos_ff,    pos_in;
   logic [TIME_BITS-1:0]    exp_ff,    exp_in;
   logic [HANDLE_BITS-1:0]  hnd_ff,    hnd_in;
   logic [TIME_BITS-1:0]    tmo_ff,    tmo_in;
   logic [HANDLE_BITS-1:0]  target_ff, target_in;
   logic [REARM_BITS-1:0]   rearm_ff,  rearm_in;
   logic [STATUS_BITS-1:0]  stat_ff,   stat_in;
   logic [HANDLE_BITS-1:0]  rhnd_ff,   rhnd_in;
   logic [TIME_BITS-1:0]    ttl_ff,    ttl_in;
   logic                    due_ff,    due_in;
   logic                    valid_ff,  valid_in;

   always_comb begin
      state_in    = state_ff;
      time_in     = time_ff;
      nhc_in      = nhc_ff;
      count_in    = count_ff;
      pos_in      = pos_ff;
      exp_in      = exp_ff;
      hnd_in      = hnd_ff;
      tmo_in      = tmo_ff;
      target_in   = target_ff;
      rearm_in    = rearm_ff;
      stat_in     = stat_ff;
      rhnd_in     = rhnd_ff;
      ttl_in      = ttl_ff;
      due_in      = due_ff;
      valid_in    = 1'b0;
      slot_cmd.op    = SLOT_NONE;
      slot_cmd.pos   = pos_ff[IDX_BITS-1:0];
      slot_cmd.entry = '{expiry: exp_ff, handle: hnd_ff, timeout: tmo_ff};
      slot_rd_idx = pos_ff[IDX_BITS-1:0];
      alu_a       = time_ff;
      alu_b       = tmo_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               target_in = req_target_handle;
               rearm_in  = req_rearm_value;
               stat_in   = STATUS_OK;
               rhnd_in   = '0;
               pos_in    = '0;
               unique case (req_kind)
                  KIND_ADD: begin
                     if (count_ff == COUNT_BITS'(DEPTH)) begin
                        stat_in  = STATUS_FULL;
                        state_in = ST_RESULT;
                     end else begin
                        hnd_in   = nhc_ff;
                        rhnd_in  = nhc_ff;
                        nhc_in   = nhc_ff + 1'b1;
                        tmo_in   = req_delay_ticks;
                        state_in = ST_ADD_SUM;
                     end
                  end
                  KIND_REMOVE: begin
                     state_in = ST_SRCH;
                  end
                  KIND_TICK: begin
                     state_in = ST_TICK;
                  end
                  KIND_EXEC: begin
                     if (count_ff == '0) begin
                        stat_in  = STATUS_EMPTY;
                        state_in = ST_RESULT;
                     end else begin
                        state_in = ST_EXEC;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_TICK: begin
            alu_b    = TIME_BITS'(1);
            time_in  = alu_res.sum;
            state_in = ST_RESULT;
         end
         ST_EXEC: begin
            // Pop the head; a non-negative answer sends it back through insert.
            slot_rd_idx  = '0;
            hnd_in       = slot_rd.handle;
            rhnd_in      = slot_rd.handle;
            tmo_in       = (rearm_ff == '0) ? slot_rd.timeout : rearm_ff[TIME_BITS-1:0];
            slot_cmd.op  = SLOT_DROP;
            slot_cmd.pos = '0;
            count_in     = count_ff - 1'b1;
            state_in     = rearm_ff[REARM_BITS-1] ? ST_RESULT : ST_ADD_SUM;
         end
         ST_ADD_SUM: begin
            exp_in   = alu_res.sum;
            pos_in   = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            alu_a = exp_ff;
            alu_b = slot_rd.expiry;
            if (pos_ff != count_ff && alu_res.gt) begin
               pos_in = pos_ff + 1'b1;
            end else begin
               slot_cmd.op = SLOT_INSERT;
               count_in    = count_ff + 1'b1;
               state_in    = ST_RESULT;
            end
         end
         ST_SRCH: begin
            if (pos_ff == count_ff) begin
               stat_in  = STATUS_NOT_FOUND;
               state_in = ST_RESULT;
            end else if (slot_rd.handle == target_ff) begin
               slot_cmd.op = SLOT_DROP;
               count_in    = count_ff - 1'b1;
               rhnd_in     = target_ff;
               state_in    = ST_RESULT;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
         ST_RESULT: begin
            slot_rd_idx = '0;
            alu_a       = slot_rd.expiry;
            alu_b       = time_ff;
            if (count_ff == '0) begin
               ttl_in = TIME_ALL_ONES;
               due_in = 1'b0;
            end else begin
               ttl_in = alu_res.borrow ? '0 : alu_res.diff;
               due_in = !alu_res.gt;
            end
            valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         time_ff  <= '0;
         nhc_ff   <= HANDLE_BITS'(1);
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         time_ff  <= time_in;
         nhc_ff   <= nhc_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
      pos_ff    <= pos_in;
      exp_ff    <= exp_in;
      hnd_ff    <= hnd_in;
      tmo_ff    <= tmo_in;
      target_ff <= target_in;
      rearm_ff  <= rearm_in;
      stat_ff   <= stat_in;
      rhnd_ff   <= rhnd_in;
      ttl_ff    <= ttl_in;
      due_ff    <= due_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = valid_ff;
   assign rsp_status        = stat_ff;
   assign rsp_result_handle = rhnd_ff;
   assign rsp_time_to_head  = ttl_ff;
   assign rsp_head_due      = due_ff;
   assign rsp_entry_count   = count_ff;

endmodule

FILE: rtl/core/sorted_timer_queue.sv
// Sorted timer queue. A tick increments time; remove searches the slots by
// handle; add sums the expiry and scans for the insert position through the
// shared unit; execute pops the head and re-adds it if the re-arm value is
// not negative; full or empty skip the scan. Scans take one slot per cycle.
// The next command is taken in the cycle rsp_valid is high; responses cannot be
// stalled. Synchronous reset empties the queue, zeroes time and sets handle 1.
// Depends on stq_pkg, stq_ctrl, stq_slots and stq_alu.
module sorted_timer_queue
   import stq_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [KIND_BITS-1:0]          req_kind,
   input  logic [TIME_BITS-1:0]          req_delay_ticks,
   input  logic [HANDLE_BITS-1:0]        req_target_handle,
   input  logic signed [REARM_BITS-1:0]  req_rearm_value,
   output logic                          rsp_valid,
   output logic [STATUS_BITS-1:0]        rsp_status,
   output logic [HANDLE_BITS-1:0]        rsp_result_handle,
   output logic [TIME_BITS-1:0]          rsp_time_to_head,
   output logic                          rsp_head_due,
   output logic [COUNT_BITS-1:0]         rsp_entry_count
);

   // Command and read port between the sequencer and the slot store.
   slot_cmd_type           slot_cmd;
   logic [IDX_BITS-1:0]    slot_rd_idx;
   slot_entry_type         slot_rd;

   // Operands and results of the one shared arithmetic unit. The sequencer
   // steers it: expiry sum on insert, ordering compare while scanning, the
   // tick increment, and the head distance while forming the response.
   logic [TIME_BITS-1:0]   alu_a;
   logic [TIME_BITS-1:0]   alu_b;
   alu_res_type            alu_res;

   stq_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_kind          (req_kind),
      .req_delay_ticks   (req_delay_ticks),
      .req_target_handle (req_target_handle),
      .req_rearm_value   (req_rearm_value),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_result_handle (rsp_result_handle),
      .rsp_time_to_head  (rsp_time_to_head),
      .rsp_head_due      (rsp_head_due),
      .rsp_entry_count   (rsp_entry_count),
      .slot_cmd          (slot_cmd),
      .slot_rd_idx       (slot_rd_idx),
      .slot_rd           (slot_rd),
      .alu_a             (alu_a),
      .alu_b             (alu_b),
      .alu_res           (alu_res)
   );

   // Slot contents need no reset: only entries below the count are ever used.
   stq_slots u_slots (
      .clock   (clock),
      .cmd     (slot_cmd),
      .rd_idx  (slot_rd_idx),
      .rd_data (slot_rd)
   );

   stq_alu u_alu (
      .op_a (alu_a),
      .op_b (alu_b),
      .res  (alu_res)
   );

endmodule

FILE: rtl/core/stq_checker.sv
// Port-level checks for the sorted timer queue, bound to the top level.
// Depends on stq_pkg and sorted_timer_queue_macros.svh.
`include "sorted_timer_queue_macros.svh"

module stq_checker
   import stq_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic                          rsp_valid,
   input  logic [TIME_BITS-1:0]          rsp_time_to_head,
   input  logic                          rsp_head_due,
   input  logic [COUNT_BITS-1:0]         rsp_entry_count
);

   // A transaction taken makes the block busy until its response.
   `STQ_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // A response shows only once the block is free again.
   `STQ_ASSERT_IMPLY(a_rsp_idle, clock, reset, rsp_valid, !busy)
   // One response per transaction: the strobe is low again after each pulse.
   `STQ_ASSERT_NEXT(a_rsp_pulse, clock, reset, rsp_valid, !rsp_valid)
   // The count never passes the queue depth.
   `STQ_ASSERT_IMPLY(a_count_max, clock, reset, rsp_valid,
                     rsp_entry_count <= COUNT_BITS'(DEPTH))
   // An empty queue reports no head.
   `STQ_ASSERT_IMPLY(a_empty_head, clock, reset, rsp_valid && rsp_entry_count == '0,
                     rsp_time_to_head == TIME_ALL_ONES && !rsp_head_due)

endmodule

bind sorted_timer_queue stq_checker u_stq_checker (.*);
